FILE: rtl/core/chlm_pkg.sv
package chlm_pkg;

    localparam int UNIT_W             = 16;
    localparam int PATTERNS_DEF       = 8;
    localparam int PATTERN_UNITS_DEF  = 32;
    localparam int CFG_W              = 4;
    localparam int SLOT_W             = 3;
    localparam int POS_W              = 5;
    localparam int CJK_NUMERALS_MAX   = 12;

    // item kinds
    localparam logic KIND_TEXT   = 1'b0;
    localparam logic KIND_PWRITE = 1'b1;

    // special units
    localparam logic [UNIT_W-1:0] U_ORDINAL  = 16'h7b2c;
    localparam logic [UNIT_W-1:0] U_CHAPTER  = 16'h7ae0;
    localparam logic [UNIT_W-1:0] U_EPISODE  = 16'h56de;
    localparam logic [UNIT_W-1:0] U_IDSPACE  = 16'h3000;
    localparam logic [UNIT_W-1:0] U_EN_DASH  = 16'h2013;
    localparam logic [UNIT_W-1:0] U_EM_DASH  = 16'h2014;
    localparam logic [UNIT_W-1:0] U_FW_ZERO  = 16'hff10;
    localparam logic [UNIT_W-1:0] U_FW_NINE  = 16'hff19;
    localparam logic [UNIT_W-1:0] U_STAR     = 16'h002a;
    localparam logic [UNIT_W-1:0] U_QUEST    = 16'h003f;

    // control group handed to the line trackers
    typedef struct packed {
        logic              step;
        logic              nonspace;
        logic              clear;
        logic [UNIT_W-1:0] unit;
    } chlm_feed_t;

    function automatic logic [UNIT_W-1:0] fold(input logic [UNIT_W-1:0] v);
        logic [UNIT_W-1:0] r;
        r = v;
        if (v inside {[16'h0041:16'h005a]}) r = v + 16'd32;
        return r;
    endfunction

    function automatic logic blank_unit(input logic [UNIT_W-1:0] v);
        return v inside {U_IDSPACE, 16'h0020, [16'h0009:16'h000d]};
    endfunction

    function automatic logic break_unit(input logic [UNIT_W-1:0] v);
        return blank_unit(v) || (v inside {16'h003a, 16'h002e, 16'h002d, U_EN_DASH, U_EM_DASH});
    endfunction

    function automatic logic is_digit(input logic [UNIT_W-1:0] v);
        return v inside {[16'h0030:16'h0039]};
    endfunction

    function automatic logic roman_unit(input logic [UNIT_W-1:0] v);
        return fold(v) inside {16'h0069, 16'h0076, 16'h0078, 16'h006c,
                               16'h0063, 16'h0064, 16'h006d};
    endfunction

    function automatic logic is_numeral(input logic [UNIT_W-1:0] v);
        return is_digit(v) || (v inside {[U_FW_ZERO:U_FW_NINE]}) ||
               (v inside {16'h3007, 16'h96f6, 16'h4e00, 16'h4e8c, 16'h4e09, 16'h56db,
                          16'h4e94, 16'h516d, 16'h4e03, 16'h516b, 16'h4e5d, 16'h5341,
                          16'h767e, 16'h5343, 16'h4e07, 16'h4e24});
    endfunction

    // letters of the word "chapter"
    function automatic logic [UNIT_W-1:0] chapter_letter(input logic [2:0] idx);
        logic [UNIT_W-1:0] r;
        case (idx)
            3'd0:    r = 16'h0063;
            3'd1:    r = 16'h0068;
            3'd2:    r = 16'h0061;
            3'd3:    r = 16'h0070;
            3'd4:    r = 16'h0074;
            3'd5:    r = 16'h0065;
            3'd6:    r = 16'h0072;
            default: r = 16'h0000;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/chapter_heading_line_matcher.sv
// an item is held in the input register, and a line's result is registered in the result
// register when its last unit is consumed, then offered from there
// throughput: one item per cycle; a line end waits only while the previous result is unread
// reset: synchronous, active low; line trackers return to line start and the
// pattern store keeps no reset, holding undefined contents until written
module chapter_heading_line_matcher
    import chlm_pkg::*;
#(
    parameter int PATTERNS      = PATTERNS_DEF,
    parameter int PATTERN_UNITS = PATTERN_UNITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_kind,
    input  logic [UNIT_W-1:0] s_unit,
    input  logic              s_line_last,
    input  logic [SLOT_W-1:0] s_slot_index,
    input  logic [POS_W-1:0]  s_unit_position,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_is_heading
);

    localparam int IW = $clog2(PATTERN_UNITS);

    logic              in_vld_reg;
    logic              kind_reg;
    logic [UNIT_W-1:0] unit_reg;
    logic              last_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [CFG_W-1:0]  active_reg;
    logic              skip_reg, skip_next;
    logic              zero_reg, zero_next;
    logic              out_vld_reg;
    logic              heading_reg;
    logic              is_text, gives_result, consume, pos_ok;
    logic              heading_next, builtin_hit;
    logic [PATTERNS-1:0] slot_accept, slot_active;
    chlm_feed_t        feed;

    // hand-off between input and result registers
    assign is_text      = (kind_reg == KIND_TEXT);
    assign gives_result = is_text && last_reg;
    assign consume      = in_vld_reg && (!gives_result || !out_vld_reg || m_ready);
    assign s_ready      = !in_vld_reg || consume;
    assign m_valid      = out_vld_reg;
    assign m_is_heading = heading_reg;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            kind_reg <= s_kind;
            unit_reg <= s_unit;
            last_reg <= s_line_last;
            slot_reg <= s_slot_index;
            pos_reg  <= s_unit_position;
        end
    end

    // slot count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
        end else if (cfg_wr_en) begin
            active_reg <= cfg_wr_data;
        end
    end

    // trimming and zero-unit cutoff
    always_comb begin
        feed.unit     = unit_reg;
        feed.nonspace = !blank_unit(unit_reg);
        feed.step     = consume && is_text && !zero_reg && (unit_reg != '0) &&
                        !(skip_reg && blank_unit(unit_reg));
        feed.clear    = consume && gives_result;
        skip_next     = skip_reg && !feed.step;
        zero_next     = zero_reg || (consume && is_text && unit_reg == '0);
    end

    assign pos_ok = (32'(pos_reg) < 32'(PATTERN_UNITS));

    // one automaton per pattern slot
    for (genvar s = 0; s < PATTERNS; s++) begin : g_slot
        logic wr_here;
        assign wr_here = consume && (kind_reg == KIND_PWRITE) && pos_ok &&
                         (32'(slot_reg) == s);
        assign slot_active[s] = (s < 32'(active_reg));
        chlm_nfa #(.PATTERN_UNITS(PATTERN_UNITS)) u_nfa (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .wr_en       (wr_here),
            .wr_pos      (IW'(pos_reg)),
            .wr_data     (unit_reg),
            .feed        (feed),
            .accept_next (slot_accept[s])
        );
    end

    chlm_builtin u_builtin (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .feed     (feed),
        .hit_next (builtin_hit)
    );

    assign heading_next = !skip_next && (builtin_hit || |(slot_accept & slot_active));

    // line trim state
    always_ff @(posedge aclk) begin
        if (!aresetn || feed.clear) begin
            skip_reg <= 1'b1;
            zero_reg <= 1'b0;
        end else begin
            skip_reg <= skip_next;
            zero_reg <= zero_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (consume && gives_result) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && gives_result) begin
            heading_reg <= heading_next;
        end
    end

    // a result appears only for a consumed line end
    a_result_from_line_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_vld_reg) |-> $past(consume && gives_result))
        else $error("result without a line end");

    // the input side only stalls with an item held
    a_stall_holds_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_vld_reg && gives_result && out_vld_reg))
        else $error("input stalled without a pending result");

    // a line end restarts trimming
    a_line_end_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && gives_result) |=> (skip_reg && !zero_reg))
        else $error("line state not restarted");

endmodule

FILE: rtl/core/chlm_nfa.sv
module chlm_nfa
    import chlm_pkg::*;
#(
    parameter int PATTERN_UNITS = PATTERN_UNITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             wr_en,
    input  logic [$clog2(PATTERN_UNITS)-1:0] wr_pos,
    input  logic [UNIT_W-1:0]                wr_data,
    input  chlm_feed_t                       feed,
    output logic                             accept_next
);

    localparam int U   = PATTERN_UNITS;
    localparam int POS = U + 1;

    logic [UNIT_W-1:0] pat_reg [U];
    logic [POS-1:0]    live_reg, live_next;
    logic [POS-1:0]    last_reg, last_next;
    logic [U-1:0]      nz, valid, star, hit;
    logic [POS-1:0]    star_mask, closed, stepped, last_closed, end_hot;
    logic [U-1:0]      adv;

    // star runs propagate like a carry chain
    function automatic logic [POS-1:0] closure(input logic [POS-1:0] b,
                                               input logic [POS-1:0] s);
        logic [POS-1:0] g;
        g = b & s;
        return b | ((g + s) ^ g ^ s);
    endfunction

    // pattern store, one unit per pattern position
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pat_reg[wr_pos] <= wr_data;
        end
    end

    // per-position decode against the current unit
    always_comb begin
        for (int i = 0; i < U; i++) begin
            nz[i]   = (pat_reg[i] != '0);
            star[i] = (pat_reg[i] == U_STAR);
            hit[i]  = (pat_reg[i] == U_QUEST) || (fold(pat_reg[i]) == fold(feed.unit));
        end
        valid[0] = nz[0];
        for (int i = 1; i < U; i++) begin
            valid[i] = valid[i-1] & nz[i];
        end
    end

    // one step of the automaton
    always_comb begin
        star_mask = {1'b0, valid & star};
        closed    = closure(live_reg, star_mask);
        adv       = closed[U-1:0] & valid & ~star & hit;
        stepped   = (closed & star_mask) | {adv, 1'b0};
        live_next = feed.step ? stepped : live_reg;
        last_next = (feed.step && feed.nonspace) ? stepped : last_reg;
    end

    // acceptance at the pattern end
    always_comb begin
        end_hot    = '0;
        end_hot[0] = ~valid[0];
        for (int i = 1; i < U; i++) begin
            end_hot[i] = valid[i-1] & ~valid[i];
        end
        end_hot[U]  = valid[U-1];
        last_closed = closure(last_next, star_mask);
        accept_next = |(last_closed & end_hot);
    end

    // live bits, back to the start position at each line end
    always_ff @(posedge aclk) begin
        if (!aresetn || feed.clear) begin
            live_reg <= POS'(1);
            last_reg <= POS'(1);
        end else begin
            live_reg <= live_next;
            last_reg <= last_next;
        end
    end

endmodule

FILE: rtl/core/chlm_builtin.sv
module chlm_builtin
    import chlm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  chlm_feed_t feed,
    output logic       hit_next
);

    typedef enum logic [1:0] {CJ_FIRST, CJ_NUM, CJ_MARK, CJ_DEAD} cjk_t;
    typedef enum logic [3:0] {
        LA_C, LA_H, LA_A, LA_P, LA_T, LA_E, LA_R,
        LA_SPACE1, LA_SPACES, LA_RUN, LA_DEAD
    } latin_t;

    cjk_t       cjk_reg, cjk_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       cjk_hit_reg, cjk_hit_next;
    latin_t     lat_reg, lat_next;
    logic       dec_reg, dec_next;
    logic       lat_hit_reg, lat_hit_next;
    logic [UNIT_W-1:0] u;

    assign u = feed.unit;

    // ordinal form: marker, numerals, chapter or episode sign, boundary
    always_comb begin
        cjk_next     = cjk_reg;
        cnt_next     = cnt_reg;
        cjk_hit_next = cjk_hit_reg;
        if (feed.step) begin
            case (cjk_reg)
                CJ_FIRST: begin
                    cjk_next = (u == U_ORDINAL) ? CJ_NUM : CJ_DEAD;
                    cnt_next = '0;
                end
                CJ_NUM: begin
                    if (cnt_reg < 4'(CJK_NUMERALS_MAX) && is_numeral(u)) begin
                        cnt_next = cnt_reg + 4'd1;
                    end else if (cnt_reg != '0 && (u == U_CHAPTER || u == U_EPISODE)) begin
                        cjk_next = CJ_MARK;
                    end else begin
                        cjk_next = CJ_DEAD;
                    end
                end
                CJ_MARK: begin
                    if (break_unit(u)) cjk_hit_next = 1'b1;
                    cjk_next = CJ_DEAD;
                end
                default: cjk_next = cjk_reg;
            endcase
        end
    end

    // latin form: word, spaces, digit or roman run, boundary
    always_comb begin
        lat_next     = lat_reg;
        dec_next     = dec_reg;
        lat_hit_next = lat_hit_reg;
        if (feed.step) begin
            case (lat_reg)
                LA_C, LA_H, LA_A, LA_P, LA_T, LA_E, LA_R: begin
                    lat_next = (fold(u) == chapter_letter(3'(lat_reg)))
                             ? latin_t'(lat_reg + 4'd1) : LA_DEAD;
                end
                LA_SPACE1: lat_next = blank_unit(u) ? LA_SPACES : LA_DEAD;
                LA_SPACES: begin
                    if (!blank_unit(u)) begin
                        if (is_digit(u)) begin
                            dec_next = 1'b1;
                            lat_next = LA_RUN;
                        end else if (roman_unit(u)) begin
                            dec_next = 1'b0;
                            lat_next = LA_RUN;
                        end else begin
                            lat_next = LA_DEAD;
                        end
                    end
                end
                LA_RUN: begin
                    if (!(dec_reg ? is_digit(u) : roman_unit(u))) begin
                        if (break_unit(u)) lat_hit_next = 1'b1;
                        lat_next = LA_DEAD;
                    end
                end
                default: lat_next = lat_reg;
            endcase
        end
    end

    assign hit_next = cjk_hit_next || lat_hit_next || (cjk_next == CJ_MARK) ||
                      (lat_next == LA_RUN);

    // state, cleared at each line end
    always_ff @(posedge aclk) begin
        if (!aresetn || feed.clear) begin
            cjk_reg     <= CJ_FIRST;
            cnt_reg     <= '0;
            cjk_hit_reg <= 1'b0;
            lat_reg     <= LA_C;
            dec_reg     <= 1'b0;
            lat_hit_reg <= 1'b0;
        end else begin
            cjk_reg     <= cjk_next;
            cnt_reg     <= cnt_next;
            cjk_hit_reg <= cjk_hit_next;
            lat_reg     <= lat_next;
            dec_reg     <= dec_next;
            lat_hit_reg <= lat_hit_next;
        end
    end

endmodule
